@@ src/multi_source_trigger_qualifier_top_assert.svh @@
// assertion macros used by the qualifier back end
`ifndef MULTI_SOURCE_TRIGGER_QUALIFIER_TOP_ASSERT_SVH
`define MULTI_SOURCE_TRIGGER_QUALIFIER_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define MSTQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mstq assertion failed");

// next-cycle implication, disabled in reset
`define MSTQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mstq assertion failed");

`endif

@@ src/mstq_pkg.sv @@
package mstq_pkg;

    localparam logic [1:0] CMD_POLL   = 2'd0;
    localparam logic [1:0] CMD_TOUCH  = 2'd1;
    localparam logic [1:0] CMD_MANUAL = 2'd2;

    localparam logic [1:0] REG_ENABLE   = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE = 2'd1;
    localparam logic [1:0] REG_INTERVAL = 2'd2;
    localparam logic [1:0] REG_HOLDOFF  = 2'd3;

    localparam logic [3:0]  ENABLE_RESET   = 4'd7;
    localparam logic [15:0] DEBOUNCE_RESET = 16'd200;
    localparam logic [31:0] INTERVAL_RESET = 32'd30000;
    localparam logic [15:0] HOLDOFF_RESET  = 16'd5000;

    localparam logic [7:0] SENSOR_INTENSITY = 8'd100;
    localparam logic [7:0] AUTO_INTENSITY   = 8'd50;

    // enable mask bits
    localparam int EN_TOUCH    = 0;
    localparam int EN_APPROACH = 1;
    localparam int EN_VOICE    = 2;
    localparam int EN_AUTO     = 3;

    typedef enum logic [2:0] {
        TYPE_UNKNOWN  = 3'd0,
        TYPE_TOUCH    = 3'd1,
        TYPE_APPROACH = 3'd2,
        TYPE_VOICE    = 3'd3,
        TYPE_AUTO     = 3'd4
    } trig_type_t;

    typedef enum logic [1:0] {
        OP_POLL,
        OP_TOUCH,
        OP_MANUAL,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] now_ms;
        logic        voice_level;
        logic        approach_level;
        logic        playing;
        logic [2:0]  manual_type;
        logic [7:0]  manual_intensity;
    } item_t;

    typedef struct packed {
        trig_type_t  ev_type;
        logic [31:0] ev_time;
        logic [7:0]  intensity;
        logic [31:0] type_count;
        logic [31:0] total_fired;
    } event_t;

endpackage

@@ src/mstq_front.sv @@
module mstq_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [1:0]      cmd,
    input  logic [31:0]     now_ms,
    input  logic            voice_level,
    input  logic            approach_level,
    input  logic            playing,
    input  logic [2:0]      manual_type,
    input  logic [7:0]      manual_intensity,
    output logic            q_valid,
    output mstq_pkg::item_t q_item,
    input  logic            q_pop
);

    mstq_pkg::item_t fifo_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    mstq_pkg::item_t item_dec;
    logic            push;

    // classify the incoming transaction
    always_comb
    begin
        item_dec.now_ms           = now_ms;
        item_dec.voice_level      = voice_level;
        item_dec.approach_level   = approach_level;
        item_dec.playing          = playing;
        item_dec.manual_type      = manual_type;
        item_dec.manual_intensity = manual_intensity;
        case (cmd)
            mstq_pkg::CMD_POLL:   item_dec.op = mstq_pkg::OP_POLL;
            mstq_pkg::CMD_TOUCH:  item_dec.op = mstq_pkg::OP_TOUCH;
            mstq_pkg::CMD_MANUAL:
            begin
                // manual types above auto are dropped here
                if (manual_type <= 3'(mstq_pkg::TYPE_AUTO))
                    item_dec.op = mstq_pkg::OP_MANUAL;
                else
                    item_dec.op = mstq_pkg::OP_NONE;
            end
            default:              item_dec.op = mstq_pkg::OP_NONE;
        endcase
    end

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
            count_next = count_reg + 2'd1;
        else if (!push && q_pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= item_dec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

@@ src/mstq_back.sv @@
`include "multi_source_trigger_qualifier_top_assert.svh"

module mstq_back #(
    parameter int TIME_WIDTH  = 32,
    parameter int COUNT_WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data,
    input  logic             q_valid,
    input  mstq_pkg::item_t  q_item,
    output logic             q_pop,
    input  logic             out_stall,
    output logic             out_valid,
    output mstq_pkg::event_t out_ev,
    output logic             out_last
);

    localparam int CMPW = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

    typedef enum logic {
        ST_STEP,
        ST_FLUSH
    } state_t;

    typedef enum logic [1:0] {
        STEP_VOICE,
        STEP_APPROACH,
        STEP_AUTO
    } step_t;

    // configuration
    logic [3:0]  enable_reg;
    logic [15:0] debounce_reg;
    logic [31:0] interval_reg;
    logic [15:0] holdoff_reg;

    // qualifier state
    logic [TIME_WIDTH-1:0]  touch_last_reg;
    logic [TIME_WIDTH-1:0]  approach_last_reg;
    logic [TIME_WIDTH-1:0]  voice_last_reg;
    logic [TIME_WIDTH-1:0]  auto_last_reg;
    logic [TIME_WIDTH-1:0]  global_last_reg;
    logic                   voice_seen_reg;
    logic                   approach_seen_reg;
    logic [COUNT_WIDTH-1:0] type_cnt_reg [4];
    logic [COUNT_WIDTH-1:0] all_cnt_reg;

    // sequencer and output side
    state_t           state_reg;
    state_t           state_next;
    step_t            step_reg;
    step_t            step_next;
    logic             pend_valid_reg;
    logic             pend_valid_next;
    mstq_pkg::event_t pend_ev_reg;
    mstq_pkg::event_t pend_ev_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    mstq_pkg::event_t out_ev_reg;
    mstq_pkg::event_t out_ev_next;
    logic             out_last_reg;
    logic             out_last_next;

    logic [TIME_WIDTH-1:0]  now_t;
    logic                   is_voice;
    logic                   is_appr;
    logic                   is_auto;
    logic                   is_touch;
    logic                   is_manual;
    logic                   final_step;
    logic                   attempt;
    logic [TIME_WIDTH-1:0]  src_last;
    logic [TIME_WIDTH-1:0]  since_src;
    logic [TIME_WIDTH-1:0]  since_glob;
    logic [TIME_WIDTH-1:0]  since_auto;
    logic                   deb_ok;
    logic                   hold_ok;
    logic                   src_upd;
    logic                   play_block;
    logic                   auto_fire;
    logic                   fire;
    mstq_pkg::trig_type_t   ev_type;
    logic [2:0]             ev_code;
    logic [7:0]             ev_int;
    logic [1:0]             ctr_idx;
    logic                   has_ctr;
    logic [COUNT_WIDTH-1:0] tc_new;
    logic [COUNT_WIDTH-1:0] all_new;
    mstq_pkg::event_t       new_ev;
    logic                   can_move;
    logic                   step_go;
    logic                   fire_go;

    assign now_t     = TIME_WIDTH'(q_item.now_ms);
    assign is_voice  = (q_item.op == mstq_pkg::OP_POLL) && (step_reg == STEP_VOICE);
    assign is_appr   = (q_item.op == mstq_pkg::OP_POLL) && (step_reg == STEP_APPROACH);
    assign is_auto   = (q_item.op == mstq_pkg::OP_POLL) && (step_reg == STEP_AUTO);
    assign is_touch  = (q_item.op == mstq_pkg::OP_TOUCH);
    assign is_manual = (q_item.op == mstq_pkg::OP_MANUAL);
    assign final_step = (q_item.op != mstq_pkg::OP_POLL) || (step_reg == STEP_AUTO);

    // rising edge of a level, or a touch press, makes an attempt
    always_comb
    begin
        attempt  = 1'b0;
        src_last = touch_last_reg;
        if (is_voice)
        begin
            attempt  = enable_reg[mstq_pkg::EN_VOICE] && q_item.voice_level && !voice_seen_reg;
            src_last = voice_last_reg;
        end
        else if (is_appr)
        begin
            attempt  = enable_reg[mstq_pkg::EN_APPROACH] && q_item.approach_level
                       && !approach_seen_reg;
            src_last = approach_last_reg;
        end
        else if (is_touch)
        begin
            attempt  = enable_reg[mstq_pkg::EN_TOUCH];
        end
    end

    // elapsed times wrap at the time width
    assign since_src  = now_t - src_last;
    assign since_glob = now_t - global_last_reg;
    assign since_auto = now_t - auto_last_reg;

    assign deb_ok     = CMPW'(since_src) >= CMPW'(debounce_reg);
    assign hold_ok    = CMPW'(since_glob) >= CMPW'(holdoff_reg);
    assign src_upd    = attempt && deb_ok;
    assign play_block = src_upd && q_item.playing;
    assign auto_fire  = is_auto && enable_reg[mstq_pkg::EN_AUTO]
                        && (CMPW'(since_auto) >= CMPW'(interval_reg));
    assign fire       = (src_upd && !q_item.playing && hold_ok) || auto_fire || is_manual;

    always_comb
    begin
        ev_type = mstq_pkg::TYPE_TOUCH;
        ev_int  = mstq_pkg::SENSOR_INTENSITY;
        if (is_voice)
            ev_type = mstq_pkg::TYPE_VOICE;
        else if (is_appr)
            ev_type = mstq_pkg::TYPE_APPROACH;
        else if (is_auto)
        begin
            ev_type = mstq_pkg::TYPE_AUTO;
            ev_int  = mstq_pkg::AUTO_INTENSITY;
        end
        else if (is_manual)
        begin
            ev_type = mstq_pkg::trig_type_t'(q_item.manual_type);
            ev_int  = q_item.manual_intensity;
        end
    end

    assign ev_code = ev_type;
    assign has_ctr = (ev_type != mstq_pkg::TYPE_UNKNOWN);
    assign ctr_idx = 2'(ev_code - 3'd1);
    assign tc_new  = type_cnt_reg[ctr_idx] + 1'b1;
    assign all_new = all_cnt_reg + 1'b1;

    always_comb
    begin
        new_ev.ev_type     = ev_type;
        new_ev.ev_time     = 32'(now_t);
        new_ev.intensity   = ev_int;
        new_ev.type_count  = has_ctr ? 32'(tc_new) : 32'd0;
        new_ev.total_fired = 32'(all_new);
    end

    // an event is held back until the next one or the end of the item decides last
    assign can_move = !out_valid_reg || !out_stall;
    assign step_go  = (state_reg == ST_STEP) && q_valid
                      && (can_move || (!pend_valid_reg && !(fire && final_step)));
    assign fire_go  = step_go && fire;
    assign q_pop    = step_go && final_step;

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        pend_valid_next = pend_valid_reg;
        pend_ev_next    = pend_ev_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_ev_next     = out_ev_reg;
        out_last_next   = out_last_reg;
        case (state_reg)
            ST_STEP:
            begin
                if (step_go)
                begin
                    if (final_step)
                        step_next = STEP_VOICE;
                    else
                    begin
                        case (step_reg)
                            STEP_VOICE:    step_next = STEP_APPROACH;
                            STEP_APPROACH: step_next = STEP_AUTO;
                            default:       step_next = STEP_VOICE;
                        endcase
                    end
                    if (fire && pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_ev_next    = pend_ev_reg;
                        out_last_next  = 1'b0;
                        pend_ev_next   = new_ev;
                        if (final_step)
                            state_next = ST_FLUSH;
                    end
                    else if (fire && final_step)
                    begin
                        out_valid_next = 1'b1;
                        out_ev_next    = new_ev;
                        out_last_next  = 1'b1;
                    end
                    else if (fire)
                    begin
                        pend_valid_next = 1'b1;
                        pend_ev_next    = new_ev;
                    end
                    else if (final_step && pend_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_ev_next     = pend_ev_reg;
                        out_last_next   = 1'b1;
                        pend_valid_next = 1'b0;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (can_move)
                begin
                    out_valid_next  = 1'b1;
                    out_ev_next     = pend_ev_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_STEP;
                end
            end
            default: state_next = ST_STEP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_STEP;
            step_reg       <= STEP_VOICE;
            pend_valid_reg <= 1'b0;
            pend_ev_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_ev_reg     <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            pend_valid_reg <= pend_valid_next;
            pend_ev_reg    <= pend_ev_next;
            out_valid_reg  <= out_valid_next;
            out_ev_reg     <= out_ev_next;
            out_last_reg   <= out_last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= mstq_pkg::ENABLE_RESET;
            debounce_reg <= mstq_pkg::DEBOUNCE_RESET;
            interval_reg <= mstq_pkg::INTERVAL_RESET;
            holdoff_reg  <= mstq_pkg::HOLDOFF_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                mstq_pkg::REG_ENABLE:   enable_reg   <= cfg_data[3:0];
                mstq_pkg::REG_DEBOUNCE: debounce_reg <= cfg_data[15:0];
                mstq_pkg::REG_INTERVAL: interval_reg <= cfg_data;
                mstq_pkg::REG_HOLDOFF:  holdoff_reg  <= cfg_data[15:0];
                default:                enable_reg   <= enable_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touch_last_reg    <= '0;
            approach_last_reg <= '0;
            voice_last_reg    <= '0;
            auto_last_reg     <= '0;
            global_last_reg   <= '0;
            voice_seen_reg    <= 1'b0;
            approach_seen_reg <= 1'b0;
            type_cnt_reg[0]   <= '0;
            type_cnt_reg[1]   <= '0;
            type_cnt_reg[2]   <= '0;
            type_cnt_reg[3]   <= '0;
            all_cnt_reg       <= '0;
        end
        else if (step_go)
        begin
            // seen bit follows the level while the source is enabled
            if (is_voice && enable_reg[mstq_pkg::EN_VOICE])
                voice_seen_reg <= q_item.voice_level;
            if (is_appr && enable_reg[mstq_pkg::EN_APPROACH])
                approach_seen_reg <= q_item.approach_level;
            if (src_upd && is_voice)
                voice_last_reg <= now_t;
            if (src_upd && is_appr)
                approach_last_reg <= now_t;
            if (src_upd && is_touch)
                touch_last_reg <= now_t;
            if (auto_fire)
                auto_last_reg <= now_t;
            if (fire || play_block)
                global_last_reg <= now_t;
            if (fire)
            begin
                all_cnt_reg <= all_new;
                if (has_ctr)
                    type_cnt_reg[ctr_idx] <= tc_new;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_ev    = out_ev_reg;
    assign out_last  = out_last_reg;

    `MSTQ_ASSERT_NOW(a_flush_has_pend, state_reg == ST_FLUSH, pend_valid_reg)
    `MSTQ_ASSERT_NOW(a_pend_item_open, pend_valid_reg && state_reg == ST_STEP, q_valid)
    `MSTQ_ASSERT_NXT(a_total_counts_fire, fire_go, all_cnt_reg == $past(all_cnt_reg) + 1'b1)
    `MSTQ_ASSERT_NXT(a_total_hold_idle, !fire_go, $stable(all_cnt_reg))

endmodule

@@ src/multi_source_trigger_qualifier_top.sv @@
// channel    direction  handshake               payload
// in         input      in_valid / in_stall     cmd, now_ms, levels, playing, manual fields
// out        output     out_valid / out_stall   trig_kind .. total_fired, last
// cfg        input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// touch, manual and ignored items take one sequencer cycle; a poll takes three
// (voice, approach, auto steps), plus one cycle when its final event must wait
// behind a held one. a two-entry queue sits between the front and the sequencer.
// reset is asynchronous, active low, and restores the register defaults.
// a stalled output holds the sequencer while an event is held back or a step sends one.
// cfg_ready is always high; writes take effect on the next cycle.
module multi_source_trigger_qualifier_top #(
    parameter int TIME_WIDTH  = 32,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [31:0] now_ms,
    input  logic        voice_level,
    input  logic        approach_level,
    input  logic        playing,
    input  logic [2:0]  manual_type,
    input  logic [7:0]  manual_intensity,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  trig_kind,
    output logic [31:0] event_time,
    output logic [7:0]  intensity,
    output logic [31:0] type_count,
    output logic [31:0] total_fired,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic             q_valid;
    logic             q_pop;
    mstq_pkg::item_t  q_item;
    mstq_pkg::event_t out_ev;

    assign cfg_ready = 1'b1;

    mstq_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cmd              (cmd),
        .now_ms           (now_ms),
        .voice_level      (voice_level),
        .approach_level   (approach_level),
        .playing          (playing),
        .manual_type      (manual_type),
        .manual_intensity (manual_intensity),
        .q_valid          (q_valid),
        .q_item           (q_item),
        .q_pop            (q_pop)
    );

    mstq_back #(
        .TIME_WIDTH  (TIME_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_ev    (out_ev),
        .out_last  (last)
    );

    assign trig_kind   = out_ev.ev_type;
    assign event_time  = out_ev.ev_time;
    assign intensity   = out_ev.intensity;
    assign type_count  = out_ev.type_count;
    assign total_fired = out_ev.total_fired;

endmodule
